/* hdl/aolm_pkg.sv */
// Shared types, constants and helpers for the alarm output line monitor.
// No dependencies; used by aolm_sampler and alarm_output_line_monitor_core.
package aolm_pkg;

  localparam int TIMER_BITS = 16;
  localparam int CFG_BITS = 16;
  localparam int CFG_INDEX_BITS = 8;
  localparam int NUM_LINES = 8;
  localparam int NUM_STATE_LINES = 5;
  localparam int NUM_FLAGS = 3;

  typedef logic [TIMER_BITS-1:0] timer_t;
  typedef logic [CFG_BITS-1:0] cfg_data_t;
  typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;
  typedef logic [NUM_LINES-1:0] line_vec_t;
  typedef logic [NUM_FLAGS-1:0] flag_vec_t;

  localparam logic [31:0] TIMER_MAX = (32'd1 << TIMER_BITS) - 32'd1;

  localparam cfg_index_t CFG_CHECK_PERIOD = 8'd0;
  localparam cfg_index_t CFG_SETTLE = 8'd1;

  localparam cfg_data_t CHECK_PERIOD_RESET = 16'd100;
  localparam cfg_data_t SETTLE_RESET = 16'd500;

  localparam line_vec_t LINES_IDLE = '1;

  typedef enum logic [2:0] {
    ST_DISARMED  = 3'd0,
    ST_ARMED_AWAY = 3'd1,
    ST_ARMED_HOME = 3'd2,
    ST_ENTRY     = 3'd3,
    ST_EXIT      = 3'd4,
    ST_TRIGGERED = 3'd5
  } panel_state_t;

  typedef struct packed {
    logic         change;
    panel_state_t state;
    flag_vec_t    flags;
  } aolm_status_t;

  // Clamps a register value to what the timers can hold.
  function automatic timer_t timer_limit(input cfg_data_t v);
    logic [31:0] w;
    w = {{(32 - CFG_BITS){1'b0}}, v};
    if (w > TIMER_MAX) begin
      w = TIMER_MAX;
    end
    return timer_t'(w);
  endfunction

endpackage

/* hdl/aolm_sampler.sv */
// Line sampler: sample period counter, last sampled levels, pending state and flags.
// Depends on aolm_pkg.
module aolm_sampler import aolm_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  timer_t       check_period,
  input  logic         item_acc,
  input  line_vec_t    levels,
  output aolm_status_t status
);

  line_vec_t    sampled_levels;
  panel_state_t pending_state;
  flag_vec_t    status_flags;
  timer_t       sample_cnt;

  line_vec_t    diff;
  panel_state_t state_next;
  flag_vec_t    flags_next;
  logic         change;
  logic         sample_now;

  assign sample_now = (sample_cnt == '0);
  assign diff = levels ^ sampled_levels;

  always_comb begin
    state_next = pending_state;
    flags_next = status_flags;
    change = 1'b0;
    if (sample_now) begin
      for (int i = 0; i < NUM_STATE_LINES; i++) begin
        if (diff[i] && !levels[i]) begin
          change = 1'b1;
          state_next = panel_state_t'(3'(i + 1));
        end
      end
      for (int j = 0; j < NUM_FLAGS; j++) begin
        if (diff[NUM_STATE_LINES + j]) begin
          change = 1'b1;
          flags_next[j] = !levels[NUM_STATE_LINES + j];
        end
      end
      if (state_next != ST_DISARMED && (&levels[NUM_STATE_LINES-1:0])) begin
        change = 1'b1;
        state_next = ST_DISARMED;
      end
    end
  end

  assign status.change = change;
  assign status.state = state_next;
  assign status.flags = flags_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      sampled_levels <= LINES_IDLE;
      pending_state <= ST_DISARMED;
      status_flags <= '0;
      sample_cnt <= '0;
    end else if (item_acc) begin
      if (sample_now) begin
        sample_cnt <= check_period;
        sampled_levels <= levels;
        pending_state <= state_next;
        status_flags <= flags_next;
      end else begin
        sample_cnt <= sample_cnt - timer_t'(1);
      end
    end
  end

endmodule

/* hdl/alarm_output_line_monitor_core.sv */
// Top level of the alarm output line monitor: config registers, settle timer, result register.
// Depends on aolm_pkg and aolm_sampler.
//
//  Channel  Dir  Handshake                 Content
//  s_*      in   s_tvalid / s_tready       one tick with eight active-low lines
//  m_*      out  m_tvalid / m_tready       state report, at most one per tick
//  cfg_*    in   cfg_valid / cfg_ready     register index and write data
//
// Each tick request is handled when accepted, so one request enters per clock while s_tready is high.
// A report appears in the cycle after the tick that ends the settle delay.
// Reset loads the default period and settle values and clears all timers.
// s_tready drops only while a report is held and m_tready is low.
// Configuration writes are always accepted.
module alarm_output_line_monitor_core import aolm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // full_armed_line, part_armed_line, entry_line, exit_line,
                                // triggered_line, ready_line, fault_line, arm_failed_line
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // panel_state[2:0], ready_flag, fault_flag,
                                // arm_failed_flag, two zero bits
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  cfg_index_t cfg_index,
  input  cfg_data_t  cfg_data
);

  timer_t       check_period;
  timer_t       settle_ticks;
  timer_t       settle_cnt;
  logic         settle_pend;
  logic         item_acc;
  logic         emit;
  aolm_status_t stat;
  panel_state_t out_state;
  flag_vec_t    out_flags;

  assign cfg_ready = 1'b1;
  assign s_tready = !m_tvalid || m_tready;
  assign item_acc = s_tvalid && s_tready;
  assign emit = item_acc && !stat.change && settle_pend && (settle_cnt == '0);

  aolm_sampler u_sampler (
    .clk          (clk),
    .rst          (rst),
    .check_period (check_period),
    .item_acc     (item_acc),
    .levels       (s_tdata),
    .status       (stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      check_period <= timer_limit(CHECK_PERIOD_RESET);
      settle_ticks <= timer_limit(SETTLE_RESET);
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_CHECK_PERIOD) begin
        check_period <= timer_limit(cfg_data);
      end else if (cfg_index == CFG_SETTLE) begin
        settle_ticks <= timer_limit(cfg_data);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      settle_cnt <= '0;
      settle_pend <= 1'b0;
    end else if (item_acc) begin
      if (stat.change) begin
        settle_cnt <= settle_ticks;
        settle_pend <= 1'b1;
      end else if (settle_pend) begin
        if (settle_cnt != '0) begin
          settle_cnt <= settle_cnt - timer_t'(1);
        end else begin
          settle_pend <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_state <= stat.state;
      out_flags <= stat.flags;
    end
  end

  assign m_tdata = {2'b00, out_flags, out_state};

`ifndef SYNTH
  a_change_arms_settle: assert property (@(posedge clk) disable iff (rst)
    (item_acc && stat.change) |=> settle_pend)
    else $error("change did not start the settle delay");

  a_report_ends_settle: assert property (@(posedge clk) disable iff (rst)
    emit |=> (m_tvalid && !settle_pend))
    else $error("report did not end the settle delay");

  a_report_state_legal: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[2:0] <= 3'd5))
    else $error("reported state out of range");

  a_no_report_on_change: assert property (@(posedge clk) disable iff (rst)
    (item_acc && stat.change) |-> !emit)
    else $error("report on a tick with a change");
`endif

endmodule

/* tb/sv/alarm_output_line_monitor_core_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for alarm_output_line_monitor_core: tick stream in, state reports out.
// It predicts every report from the accepted ticks and the register settings it has written.
// Depends on aolm_pkg and the core RTL only.
module alarm_output_line_monitor_core_tb;
  import aolm_pkg::*;

  localparam int LATENCY_CYCLES = 4;
  localparam int SHOWN_ERRORS = 50;
  localparam cfg_index_t CFG_UNUSED = CFG_SETTLE + 8'd1;
  localparam cfg_index_t CFG_LAST_INDEX = '1;
  localparam cfg_data_t TIMER_FULL = '1;

  typedef struct packed {
    logic         arm_failed;
    logic         fault;
    logic         ready;
    panel_state_t state;
  } alarm_report_t;

  logic clk = 1'b0;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [7:0] s_tdata;
  logic m_tvalid;
  logic m_tready;
  logic [7:0] m_tdata;
  logic cfg_valid;
  logic cfg_ready;
  cfg_index_t cfg_index;
  cfg_data_t cfg_data;

  timer_t period_cfg = CHECK_PERIOD_RESET;
  timer_t settle_cfg = SETTLE_RESET;
  line_vec_t lv_sampled = LINES_IDLE;
  panel_state_t st_pending = ST_DISARMED;
  flag_vec_t flags_now = '0;
  timer_t sample_cd = '0;
  timer_t settle_cd = '0;
  logic settle_armed = 1'b0;

  alarm_report_t expected_reports[$];
  int reports_made = 0;
  int mismatches = 0;
  int burst_left = 0;
  int hold_off_cycles = 0;

  alarm_output_line_monitor_core DUT (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    if (mismatches < SHOWN_ERRORS) begin
      $display("[%0t] ERROR: %s", $time, msg);
    end
    mismatches++;
  endtask

  task automatic advance_tick(input line_vec_t now);
    logic changed;
    line_vec_t diff;
    alarm_report_t rep;
    changed = 1'b0;
    if (sample_cd == '0) begin
      sample_cd = period_cfg;
      diff = now ^ lv_sampled;
      for (int i = 0; i < NUM_STATE_LINES; i++) begin
        if (diff[i] && !now[i]) begin
          changed = 1'b1;
          st_pending = panel_state_t'(3'(i + 1));
        end
      end
      for (int i = 0; i < NUM_FLAGS; i++) begin
        if (diff[NUM_STATE_LINES + i]) begin
          changed = 1'b1;
          flags_now[i] = !now[NUM_STATE_LINES + i];
        end
      end
      lv_sampled = now;
      if (st_pending != ST_DISARMED && (&now[NUM_STATE_LINES-1:0])) begin
        changed = 1'b1;
        st_pending = ST_DISARMED;
      end
    end else begin
      sample_cd--;
    end
    if (changed) begin
      settle_cd = settle_cfg;
      settle_armed = 1'b1;
    end else if (settle_armed) begin
      if (settle_cd != '0) begin
        settle_cd--;
      end else begin
        settle_armed = 1'b0;
        rep.state = st_pending;
        rep.ready = flags_now[0];
        rep.fault = flags_now[1];
        rep.arm_failed = flags_now[2];
        expected_reports.push_back(rep);
        reports_made++;
      end
    end
  endtask

  task automatic send_tick(input line_vec_t lv);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(6, 1);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(40, 1);
    end
    s_tvalid <= 1'b1;
    s_tdata <= lv;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    advance_tick(lv);
    burst_left--;
  endtask

  task automatic write_register(input cfg_index_t idx, input cfg_data_t val, input bit last_write);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (last_write) begin
      cfg_valid <= 1'b0;
    end
    case (idx)
      CFG_CHECK_PERIOD: period_cfg = val;
      CFG_SETTLE: settle_cfg = val;
      default: ;
    endcase
  endtask

  task automatic set_timing(input cfg_data_t period, input cfg_data_t settle);
    write_register(CFG_CHECK_PERIOD, period, 1'b0);
    write_register(CFG_SETTLE, settle, 1'b1);
  endtask

  task automatic wait_for_reports();
    s_tvalid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (LATENCY_CYCLES) @(posedge clk);
  endtask

  function automatic line_vec_t next_levels(input line_vec_t prev);
    line_vec_t lv;
    lv = prev;
    case ($urandom_range(19))
      0: lv = line_vec_t'($urandom);
      1: lv = prev ^ (line_vec_t'(1) << $urandom_range(NUM_LINES - 1));
      2: lv = {prev[NUM_LINES-1:NUM_STATE_LINES],
               ~(5'b00001 << $urandom_range(NUM_STATE_LINES - 1))};
      3: lv = {prev[NUM_LINES-1:NUM_STATE_LINES], 5'b11111};
      default: ;
    endcase
    return lv;
  endfunction

  // Defaults after reset: two asserted lines, then steady lines until the report.
  task automatic test_reset_defaults();
    int start;
    start = reports_made;
    send_tick(8'b1101_1011);
    while (reports_made == start || sample_cd != '0) send_tick(lv_sampled);
    wait_for_reports();
  endtask

  task automatic test_directed_lines();
    line_vec_t pattern [22] = '{8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFE, 8'hFE, 8'hFD, 8'hFD,
                                8'hFB, 8'hFB, 8'hF7, 8'hF7, 8'hEF, 8'hEF, 8'hFF, 8'hFF,
                                8'hDF, 8'hBF, 8'h7F, 8'h7F, 8'hE0, 8'hE0};
    write_register(CFG_UNUSED, cfg_data_t'($urandom), 1'b0);
    write_register(CFG_LAST_INDEX, cfg_data_t'($urandom), 1'b0);
    set_timing('0, '0);
    foreach (pattern[i]) send_tick(pattern[i]);
    wait_for_reports();
  endtask

  // Longest settle delay; no report may come while the lines stay quiet.
  task automatic test_settle_max();
    set_timing('0, TIMER_FULL);
    send_tick(~lv_sampled);
    repeat (100) send_tick(lv_sampled);
    wait_for_reports();
  endtask

  // Longest sampling period; once sampled under it, the lines are not sampled again for the rest of the run.
  task automatic test_period_max();
    set_timing(TIMER_FULL, '0);
    send_tick(line_vec_t'($urandom));
    repeat (100) send_tick(line_vec_t'($urandom));
    wait_for_reports();
  endtask

  // The receiver holds off while reports keep coming, so the core must stall its input.
  task automatic test_output_backpressure();
    line_vec_t base;
    set_timing('0, '0);
    base = lv_sampled;
    hold_off_cycles = 300;
    for (int k = 0; k < 200; k++) begin
      send_tick((k % 4 < 2) ? base : base ^ 8'h20);
    end
    wait_for_reports();
  endtask

  task automatic test_random_traffic();
    line_vec_t lv;
    for (int p = 0; p < 6; p++) begin
      set_timing(cfg_data_t'($urandom_range(3)), cfg_data_t'($urandom_range(6)));
      lv = lv_sampled;
      for (int k = 0; k < 60; k++) begin
        lv = next_levels(lv);
        send_tick(lv);
      end
      wait_for_reports();
    end
  endtask

  always @(posedge clk) begin : check_reports
    alarm_report_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_reports.size() == 0) begin
        report_mismatch($sformatf("report %h arrived with none expected", m_tdata));
      end else begin
        want = expected_reports.pop_front();
        if (m_tdata[2:0] !== want.state) begin
          report_mismatch($sformatf("panel_state %0d, expected %0d", m_tdata[2:0], want.state));
        end
        if (m_tdata[3] !== want.ready) begin
          report_mismatch($sformatf("ready_flag %b, expected %b", m_tdata[3], want.ready));
        end
        if (m_tdata[4] !== want.fault) begin
          report_mismatch($sformatf("fault_flag %b, expected %b", m_tdata[4], want.fault));
        end
        if (m_tdata[5] !== want.arm_failed) begin
          report_mismatch($sformatf("arm_failed_flag %b, expected %b", m_tdata[5],
                                    want.arm_failed));
        end
        if (m_tdata[7:6] !== 2'b00) begin
          report_mismatch($sformatf("padding bits %b, expected 00", m_tdata[7:6]));
        end
      end
    end
  end

  initial begin : receiver
    int seg_left;
    int seg_mode;
    logic rdy;
    seg_left = 0;
    seg_mode = 0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_cycles > 0) begin
        hold_off_cycles--;
        rdy = 1'b0;
      end else begin
        if (seg_left == 0) begin
          seg_mode = $urandom_range(2);
          seg_left = (seg_mode == 0) ? $urandom_range(8, 1) : $urandom_range(60, 10);
        end
        seg_left--;
        case (seg_mode)
          0: rdy = 1'b0;
          1: rdy = 1'b1;
          default: rdy = ($urandom_range(9) < 7);
        endcase
      end
      m_tready <= rdy;
    end
  end

  initial begin
    #400_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= LINES_IDLE;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_CHECK_PERIOD;
    cfg_data <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_directed_lines();
    test_settle_max();
    test_output_backpressure();
    test_random_traffic();
    test_period_max();
    wait_for_reports();
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
